[design/dlq_pkg.sv]
// ============================================================================
// dlq_pkg
// Shared types and constants for the doubly linked queue manager.
// ============================================================================
package dlq_pkg;

  // Fixed field widths of the item and result ports
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned QUEUE_ID_W   = 2;
  localparam int unsigned NODE_ID_W    = 6;
  localparam int unsigned LINK_VALUE_W = 32;
  localparam int unsigned PAYLOAD_W    = 32;

  // Parameter defaults
  localparam int unsigned NODE_COUNT_DEF   = 64;
  localparam int unsigned QUEUE_COUNT_DEF  = 4;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR     = 3'd0,
    MODE_INIT      = 3'd1,
    MODE_PUT_FRONT = 3'd2,
    MODE_PUT_BACK  = 3'd3,
    MODE_UNLINK    = 3'd4
  } mode_e;

endpackage

[design/dlq_vmem.sv]
// ============================================================================
// dlq_vmem
// Single write port memory with one registered read port, a per-entry valid
// bit (an invalid entry stands for the null/none/zero reset value) and a valid-clear port.
// ============================================================================
module dlq_vmem #(
  parameter int unsigned DEPTH = dlq_pkg::NODE_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          wr_vld_i,
  input  logic          clr_en_i,
  input  logic [AW-1:0] clr_addr_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  output logic          rd_vld_o
);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q, vld_d;
  logic [DW-1:0]    rd_data_q;
  logic             rd_vld_q;

  // clear wins over a write to the same entry
  always_comb begin
    vld_d = vld_q;
    if (wr_en_i) begin
      vld_d[wr_addr_i] = wr_vld_i;
    end
    if (clr_en_i) begin
      vld_d[clr_addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      rd_vld_q <= vld_d[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_vld_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // write-first bypass so a read in the same cycle sees the new data
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_vld_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

[design/doubly_linked_queue_manager_unit.sv]
// ============================================================================
// doubly_linked_queue_manager_unit
// Pool of nodes linked into doubly linked queues with head and tail pointers.
// ============================================================================
// Usage:
//   An item (mode_i, queue_id_i, node_id_i, link_value_i) is taken at a rising
//   edge with start high and busy low. busy is always low: one item can be
//   taken every cycle. Modes: clear queue, init node, put front, put back,
//   unlink node.
//   Every item gives exactly one result, shown on found_o / payload_o for one
//   cycle with result_valid_o high. The result passes the input register and
//   then the result register, in item order.
//   At the accept edge the node's next, prev, owner and payload entries are
//   read from their memories; in the following cycle all pointer updates are
//   written back (one write per memory) and the result register is loaded.
//   Memory read ports bypass the write of the item ahead, so back to back
//   items on the same nodes see up-to-date links.
//   Reset: all pointers null, all owners none, payloads zero, via valid bits;
//   no clearing pass is needed. The receiver cannot stall the result.
// ============================================================================
module doubly_linked_queue_manager_unit #(
  parameter int unsigned NODE_COUNT   = dlq_pkg::NODE_COUNT_DEF,
  parameter int unsigned QUEUE_COUNT  = dlq_pkg::QUEUE_COUNT_DEF,
  parameter int unsigned PAYLOAD_BITS = dlq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [dlq_pkg::MODE_W-1:0]        mode_i,
  input  logic [dlq_pkg::QUEUE_ID_W-1:0]    queue_id_i,
  input  logic [dlq_pkg::NODE_ID_W-1:0]     node_id_i,
  input  logic [dlq_pkg::LINK_VALUE_W-1:0]  link_value_i,
  output logic                              result_valid_o,
  output logic                              found_o,
  output logic [dlq_pkg::PAYLOAD_W-1:0]     payload_o
);

  localparam int unsigned NODE_AW = $clog2(NODE_COUNT);
  localparam int unsigned QAW     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  logic accept;

  // input register
  logic                             s1_vld_q;
  logic [dlq_pkg::MODE_W-1:0]       s1_mode_q;
  logic [dlq_pkg::QUEUE_ID_W-1:0]   s1_queue_q;
  logic [dlq_pkg::NODE_ID_W-1:0]    s1_node_q;
  logic [dlq_pkg::LINK_VALUE_W-1:0] s1_link_q;

  // memory read data for the registered item's node
  logic [NODE_AW-1:0]      nx_rd, pv_rd;
  logic                    nx_rd_vld, pv_rd_vld;
  logic [QAW-1:0]          ow_rd;
  logic                    ow_rd_vld;
  logic [PAYLOAD_BITS-1:0] py_rd;
  logic                    py_rd_vld;

  // memory write commands
  logic                    nx_we, nx_wv, nx_ce;
  logic [NODE_AW-1:0]      nx_wa, nx_wd, nx_ca;
  logic                    pv_we, pv_wv, pv_ce;
  logic [NODE_AW-1:0]      pv_wa, pv_wd, pv_ca;
  logic                    ow_we, ow_ce;
  logic [NODE_AW-1:0]      ow_wa, ow_ca;
  logic [QAW-1:0]          ow_wd;
  logic                    py_we;
  logic [NODE_AW-1:0]      py_wa;
  logic [PAYLOAD_BITS-1:0] py_wd;

  // head and tail pointers
  logic [NODE_AW-1:0]     head_idx_q [QUEUE_COUNT];
  logic [NODE_AW-1:0]     tail_idx_q [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] head_vld_q, tail_vld_q;
  logic                   hd_we, hd_wv, tl_we, tl_wv;
  logic [QAW-1:0]         hd_wq, tl_wq;
  logic [NODE_AW-1:0]     hd_wi, tl_wi;

  // stage decode
  logic [NODE_AW-1:0]           n;
  logic [QAW-1:0]               qi;
  logic                         n_ok, q_ok;
  logic [NODE_AW-1:0]           h, t;
  logic                         hv, tv;
  logic                         found_d;
  logic [dlq_pkg::PAYLOAD_W-1:0] payload_d;

  // result register
  logic                          res_vld_q;
  logic                          found_q;
  logic [dlq_pkg::PAYLOAD_W-1:0] payload_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= mode_i;
      s1_queue_q <= queue_id_i;
      s1_node_q  <= node_id_i;
      s1_link_q  <= link_value_i;
    end
  end

  // ---- node memories, read at the accept edge ----
  dlq_vmem #(.DEPTH(NODE_COUNT), .AW(NODE_AW), .DW(NODE_AW)) u_next_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (nx_we),
    .wr_addr_i  (nx_wa),
    .wr_data_i  (nx_wd),
    .wr_vld_i   (nx_wv),
    .clr_en_i   (nx_ce),
    .clr_addr_i (nx_ca),
    .rd_addr_i  (NODE_AW'(node_id_i)),
    .rd_data_o  (nx_rd),
    .rd_vld_o   (nx_rd_vld)
  );

  dlq_vmem #(.DEPTH(NODE_COUNT), .AW(NODE_AW), .DW(NODE_AW)) u_prev_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (pv_we),
    .wr_addr_i  (pv_wa),
    .wr_data_i  (pv_wd),
    .wr_vld_i   (pv_wv),
    .clr_en_i   (pv_ce),
    .clr_addr_i (pv_ca),
    .rd_addr_i  (NODE_AW'(node_id_i)),
    .rd_data_o  (pv_rd),
    .rd_vld_o   (pv_rd_vld)
  );

  dlq_vmem #(.DEPTH(NODE_COUNT), .AW(NODE_AW), .DW(QAW)) u_owner_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (ow_we),
    .wr_addr_i  (ow_wa),
    .wr_data_i  (ow_wd),
    .wr_vld_i   (1'b1),
    .clr_en_i   (ow_ce),
    .clr_addr_i (ow_ca),
    .rd_addr_i  (NODE_AW'(node_id_i)),
    .rd_data_o  (ow_rd),
    .rd_vld_o   (ow_rd_vld)
  );

  dlq_vmem #(.DEPTH(NODE_COUNT), .AW(NODE_AW), .DW(PAYLOAD_BITS)) u_payload_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (py_we),
    .wr_addr_i  (py_wa),
    .wr_data_i  (py_wd),
    .wr_vld_i   (1'b1),
    .clr_en_i   (1'b0),
    .clr_addr_i (py_wa),
    .rd_addr_i  (NODE_AW'(node_id_i)),
    .rd_data_o  (py_rd),
    .rd_vld_o   (py_rd_vld)
  );

  // ---- operation decode and pointer updates ----
  assign n    = NODE_AW'(s1_node_q);
  assign qi   = QAW'(s1_queue_q);
  assign n_ok = 32'(s1_node_q) < 32'(NODE_COUNT);
  assign q_ok = 32'(s1_queue_q) < 32'(QUEUE_COUNT);
  assign h    = head_idx_q[qi];
  assign hv   = head_vld_q[qi];
  assign t    = tail_idx_q[qi];
  assign tv   = tail_vld_q[qi];

  always_comb begin
    nx_we = 1'b0; nx_wa = n; nx_wd = n; nx_wv = 1'b0; nx_ce = 1'b0; nx_ca = n;
    pv_we = 1'b0; pv_wa = n; pv_wd = n; pv_wv = 1'b0; pv_ce = 1'b0; pv_ca = n;
    ow_we = 1'b0; ow_wa = n; ow_wd = qi; ow_ce = 1'b0; ow_ca = n;
    py_we = 1'b0; py_wa = n; py_wd = PAYLOAD_BITS'(s1_link_q);
    hd_we = 1'b0; hd_wq = qi; hd_wi = n; hd_wv = 1'b0;
    tl_we = 1'b0; tl_wq = qi; tl_wi = n; tl_wv = 1'b0;
    found_d   = 1'b0;
    payload_d = '0;
    if (s1_vld_q) begin
      unique case (s1_mode_q)
        dlq_pkg::MODE_CLEAR: begin
          if (q_ok) begin
            hd_we = 1'b1;
            tl_we = 1'b1;
          end
        end
        dlq_pkg::MODE_INIT: begin
          if (n_ok) begin
            nx_ce = 1'b1;
            pv_ce = 1'b1;
            ow_ce = 1'b1;
            py_we = 1'b1;
          end
        end
        dlq_pkg::MODE_PUT_FRONT: begin
          if (q_ok && n_ok) begin
            // old head points back to n; a self-link is undone by the clear
            pv_we = hv;
            pv_wa = h;
            pv_wv = 1'b1;
            pv_ce = 1'b1;
            ow_we = 1'b1;
            nx_we = 1'b1;
            nx_wd = h;
            nx_wv = hv;
            if (!hv && !tv) begin
              tl_we = 1'b1;
              tl_wv = 1'b1;
            end
            hd_we = 1'b1;
            hd_wv = 1'b1;
          end
        end
        dlq_pkg::MODE_PUT_BACK: begin
          if (q_ok && n_ok) begin
            nx_we = tv;
            nx_wa = t;
            nx_wv = 1'b1;
            nx_ce = 1'b1;
            ow_we = 1'b1;
            pv_we = 1'b1;
            pv_wd = t;
            pv_wv = tv;
            if (!hv && !tv) begin
              hd_we = 1'b1;
              hd_wv = 1'b1;
            end
            tl_we = 1'b1;
            tl_wv = 1'b1;
          end
        end
        dlq_pkg::MODE_UNLINK: begin
          if (n_ok && ow_rd_vld) begin
            if (pv_rd_vld) begin
              nx_we = 1'b1;
              nx_wa = pv_rd;
              nx_wd = nx_rd;
              nx_wv = nx_rd_vld;
            end else begin
              hd_we = 1'b1;
              hd_wq = ow_rd;
              hd_wi = nx_rd;
              hd_wv = nx_rd_vld;
            end
            if (nx_rd_vld) begin
              pv_we = 1'b1;
              pv_wa = nx_rd;
              pv_wd = pv_rd;
              pv_wv = pv_rd_vld;
            end else begin
              tl_we = 1'b1;
              tl_wq = ow_rd;
              tl_wi = pv_rd;
              tl_wv = pv_rd_vld;
            end
            nx_ce     = 1'b1;
            pv_ce     = 1'b1;
            ow_ce     = 1'b1;
            found_d   = 1'b1;
            payload_d = py_rd_vld ? dlq_pkg::PAYLOAD_W'(py_rd) : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      tail_vld_q <= '0;
    end else begin
      if (hd_we) begin
        head_vld_q[hd_wq] <= hd_wv;
      end
      if (tl_we) begin
        tail_vld_q[tl_wq] <= tl_wv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) begin
      head_idx_q[hd_wq] <= hd_wi;
    end
    if (tl_we) begin
      tail_idx_q[tl_wq] <= tl_wi;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q   <= found_d;
    payload_q <= payload_d;
  end

  assign result_valid_o = res_vld_q;
  assign found_o        = found_q;
  assign payload_o      = payload_q;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for doubly_linked_queue_manager_unit. A directed table
// walks the corner cases first, with the obvious results typed in. A random
// phase follows, mostly well-formed queue traffic. Typed results are checked as
// typed; all others against an in-bench model of the node pool and queue pointers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int NODES         = dlq_pkg::NODE_COUNT_DEF;
  localparam int QUEUES        = dlq_pkg::QUEUE_COUNT_DEF;
  localparam int RANDOM_ITEMS  = 650;
  localparam int DIRECTED_ROWS = 28;

  localparam logic [6:0]                 NULL_LINK      = 7'(NODES);
  localparam logic [2:0]                 NO_OWNER       = 3'(QUEUES);
  localparam logic [dlq_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [dlq_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [dlq_pkg::MODE_W-1:0]       op;
    logic [dlq_pkg::QUEUE_ID_W-1:0]   qsel;
    logic [dlq_pkg::NODE_ID_W-1:0]    nsel;
    logic [dlq_pkg::LINK_VALUE_W-1:0] word;
    logic                             typed;
    logic                             hit;
    logic [dlq_pkg::PAYLOAD_W-1:0]    data;
  } stim_row_t;

  typedef struct packed {
    logic                          hit;
    logic [dlq_pkg::PAYLOAD_W-1:0] data;
  } outcome_t;

  // typed = 1: hit/data hold the result; typed = 0: the model decides
  stim_row_t directed [DIRECTED_ROWS] = '{
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_UNLINK,    2'd3, 6'd63, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_INIT,      2'd0, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_INIT,      2'd3, 6'd63, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_INIT,      2'd1, 6'd1,  32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_INIT,      2'd2, 6'd62, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_BACK,  2'd0, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_BACK,  2'd0, 6'd1,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_FRONT, 2'd0, 6'd62, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_FRONT, 2'd3, 6'd63, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    // middle, head, then last node of queue 0; then a detached node
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd62, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd1,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0001},
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd1,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{MODE_UNUSED_LO,          2'd3, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{MODE_UNUSED_HI,          2'd0, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_BACK,  2'd3, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    // cleared queue keeps its members marked
    '{dlq_pkg::MODE_CLEAR,     2'd3, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd63, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // relinking a node that is already linked
    '{dlq_pkg::MODE_PUT_FRONT, 2'd2, 6'd1,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_FRONT, 2'd2, 6'd1,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_BACK,  2'd2, 6'd1,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd1,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_UNLINK,    2'd0, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_PUT_BACK,  2'd1, 6'd62, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    // re-init of a linked node detaches it without fixing the queue
    '{dlq_pkg::MODE_INIT,      2'd1, 6'd62, 32'h5A5A_A5A5, 1'b1, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_UNLINK,    2'd1, 6'd62, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{dlq_pkg::MODE_CLEAR,     2'd1, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic [dlq_pkg::MODE_W-1:0]       mode;
  logic [dlq_pkg::QUEUE_ID_W-1:0]   queue_id;
  logic [dlq_pkg::NODE_ID_W-1:0]    node_id;
  logic [dlq_pkg::LINK_VALUE_W-1:0] link_value;
  logic                             result_valid;
  logic                             found;
  logic [dlq_pkg::PAYLOAD_W-1:0]    payload;

  // model of the pool
  logic [6:0]                    link_next  [NODES];
  logic [6:0]                    link_prev  [NODES];
  logic [2:0]                    node_owner [NODES];
  logic [dlq_pkg::PAYLOAD_W-1:0] node_word  [NODES];
  logic [6:0]                    q_head     [QUEUES];
  logic [6:0]                    q_tail     [QUEUES];

  outcome_t due_results [$];
  int       fail_count = 0;
  int       burst_left = 0;

  doubly_linked_queue_manager_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode),
    .queue_id_i     (queue_id),
    .node_id_i      (node_id),
    .link_value_i   (link_value),
    .result_valid_o (result_valid),
    .found_o        (found),
    .payload_o      (payload)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one item to the model of the pool and gives its result
  function automatic void step_pool(input logic [dlq_pkg::MODE_W-1:0] op,
                                    input logic [dlq_pkg::QUEUE_ID_W-1:0] qsel,
                                    input logic [dlq_pkg::NODE_ID_W-1:0] nsel,
                                    input logic [dlq_pkg::LINK_VALUE_W-1:0] word,
                                    output logic hit,
                                    output logic [dlq_pkg::PAYLOAD_W-1:0] data);
    logic [6:0] nlink;
    logic [6:0] h;
    logic [6:0] t;
    logic [6:0] p;
    logic [6:0] x;
    logic [2:0] oq;
    nlink = {1'b0, nsel};
    hit   = 1'b0;
    data  = '0;
    case (op)
      dlq_pkg::MODE_CLEAR: begin
        q_head[qsel] = NULL_LINK;
        q_tail[qsel] = NULL_LINK;
      end
      dlq_pkg::MODE_INIT: begin
        link_next[nsel]  = NULL_LINK;
        link_prev[nsel]  = NULL_LINK;
        node_owner[nsel] = NO_OWNER;
        node_word[nsel]  = word;
      end
      dlq_pkg::MODE_PUT_FRONT: begin
        h = q_head[qsel];
        if (h < NODES) link_prev[h[5:0]] = nlink;
        node_owner[nsel] = {1'b0, qsel};
        link_next[nsel]  = q_head[qsel];
        link_prev[nsel]  = NULL_LINK;
        if (q_head[qsel] >= NODES && q_tail[qsel] >= NODES) q_tail[qsel] = nlink;
        q_head[qsel] = nlink;
      end
      dlq_pkg::MODE_PUT_BACK: begin
        t = q_tail[qsel];
        if (t < NODES) link_next[t[5:0]] = nlink;
        node_owner[nsel] = {1'b0, qsel};
        link_prev[nsel]  = q_tail[qsel];
        link_next[nsel]  = NULL_LINK;
        if (q_head[qsel] >= NODES && q_tail[qsel] >= NODES) q_head[qsel] = nlink;
        q_tail[qsel] = nlink;
      end
      dlq_pkg::MODE_UNLINK: begin
        oq = node_owner[nsel];
        if (oq < QUEUES) begin
          p = link_prev[nsel];
          if (p < NODES) link_next[p[5:0]] = link_next[nsel];
          else q_head[oq[1:0]] = link_next[nsel];
          x = link_next[nsel];
          if (x < NODES) link_prev[x[5:0]] = link_prev[nsel];
          else q_tail[oq[1:0]] = link_prev[nsel];
          node_owner[nsel] = NO_OWNER;
          link_next[nsel]  = NULL_LINK;
          link_prev[nsel]  = NULL_LINK;
          hit  = 1'b1;
          data = node_word[nsel];
        end
      end
      default: ;
    endcase
  endfunction

  // First node, from a random start, that is linked (or detached)
  function automatic logic [6:0] find_node(input logic want_linked);
    int s;
    int idx;
    s = $urandom_range(0, NODES - 1);
    for (int k = 0; k < NODES; k++) begin
      idx = (s + k) % NODES;
      if ((node_owner[idx] < QUEUES) == want_linked) return 7'(idx);
    end
    return NULL_LINK;
  endfunction

  task automatic send_item(input logic [dlq_pkg::MODE_W-1:0] op,
                           input logic [dlq_pkg::QUEUE_ID_W-1:0] qsel,
                           input logic [dlq_pkg::NODE_ID_W-1:0] nsel,
                           input logic [dlq_pkg::LINK_VALUE_W-1:0] word,
                           input logic typed, input logic hit_t,
                           input logic [dlq_pkg::PAYLOAD_W-1:0] data_t);
    int                            gap;
    logic                          hit;
    logic [dlq_pkg::PAYLOAD_W-1:0] data;
    outcome_t                      e;
    // bursts of random length; the long ones give stretches with no gaps
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        start      <= 1'b0;
        mode       <= 3'($urandom);
        queue_id   <= 2'($urandom);
        node_id    <= 6'($urandom);
        link_value <= $urandom;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    start      <= 1'b1;
    mode       <= op;
    queue_id   <= qsel;
    node_id    <= nsel;
    link_value <= word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    step_pool(op, qsel, nsel, word, hit, data);
    e.hit  = typed ? hit_t : hit;
    e.data = typed ? data_t : data;
    due_results.push_back(e);
  endtask

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && result_valid) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: found=%0b payload=%h", found, payload);
        fail_count++;
      end else begin
        e = due_results.pop_front();
        if (found !== e.hit) begin
          $error("found: expected %0b, got %0b", e.hit, found);
          fail_count++;
        end
        if (payload !== e.data) begin
          $error("payload: expected %h, got %h", e.data, payload);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int                               r;
    logic [6:0]                       pick;
    logic [dlq_pkg::MODE_W-1:0]       op;
    logic [dlq_pkg::QUEUE_ID_W-1:0]   qsel;
    logic [dlq_pkg::NODE_ID_W-1:0]    nsel;
    logic [dlq_pkg::LINK_VALUE_W-1:0] word;
    rst_ni     = 1'b0;
    start      = 1'b0;
    mode       = '0;
    queue_id   = '0;
    node_id    = '0;
    link_value = '0;
    for (int i = 0; i < NODES; i++) begin
      link_next[i]  = NULL_LINK;
      link_prev[i]  = NULL_LINK;
      node_owner[i] = NO_OWNER;
      node_word[i]  = '0;
    end
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = NULL_LINK;
      q_tail[i] = NULL_LINK;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].qsel, directed[i].nsel, directed[i].word,
                directed[i].typed, directed[i].hit, directed[i].data);
    end

    // mostly well-formed traffic: put detached nodes, unlink linked ones
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r    = $urandom_range(0, 99);
      qsel = 2'($urandom);
      nsel = 6'($urandom);
      case ($urandom_range(0, 7))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      if (r < 12) begin
        op = dlq_pkg::MODE_INIT;
      end else if (r < 50) begin
        op   = $urandom_range(0, 1) ? dlq_pkg::MODE_PUT_FRONT : dlq_pkg::MODE_PUT_BACK;
        pick = find_node(1'b0);
        if (pick != NULL_LINK) nsel = pick[5:0];
      end else if (r < 82) begin
        op   = dlq_pkg::MODE_UNLINK;
        pick = find_node(1'b1);
        if (pick != NULL_LINK) nsel = pick[5:0];
      end else if (r < 88) begin
        op = dlq_pkg::MODE_UNLINK;
      end else if (r < 94) begin
        op = $urandom_range(0, 1) ? dlq_pkg::MODE_PUT_FRONT : dlq_pkg::MODE_PUT_BACK;
      end else if (r < 97) begin
        op = dlq_pkg::MODE_CLEAR;
      end else begin
        op = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      end
      send_item(op, qsel, nsel, word, 1'b0, 1'b0, '0);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("doubly_linked_queue_manager_unit verification clean");
    end else begin
      $display("doubly_linked_queue_manager_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("doubly_linked_queue_manager_unit verification failed");
    $finish;
  end

endmodule
